// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the rate meter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property that must hold at every clock edge out of reset.
`define ARM_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("%m: assertion failed");
// Condition that must never be seen out of reset.
`define ARM_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("%m: forbidden condition seen");
`else
`define ARM_ASSERT(lbl, clk, rst_n, prop)
`define ARM_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

// ===== hw/rtl/arm_pkg.sv =====
// Package: widths, constants and shared types of the rate meter.
`default_nettype none
package arm_pkg;
  localparam int HISTORY_DEPTH = 20;
  localparam int COUNT_WIDTH   = 48;
  localparam int CNT_IN_W      = 48;
  localparam int ELAPSED_W     = 32;
  localparam int LIMIT_W       = 16;
  localparam int RATE_W        = 58;
  localparam int EXP_W         = 5;
  localparam int ALU_W         = 64;
  // diff * 1000 needs ten more bits than the count
  localparam int NUM_W         = COUNT_WIDTH + 10;
  localparam int DIV_CW        = $clog2(NUM_W + 1);
  localparam int HIST_LEN      = HISTORY_DEPTH - 1;
  localparam int HIST_SLOTS    = (HIST_LEN > 0) ? HIST_LEN : 1;
  localparam int HIST_IW       = (HIST_SLOTS > 1) ? $clog2(HIST_SLOTS) : 1;
  localparam int HIST_CW       = $clog2(HIST_SLOTS + 1);

  // x1000 = x1024 - x16 - x8 ; x10 = x8 + x2
  localparam int SH_K1024 = 10;
  localparam int SH_K16   = 4;
  localparam int SH_K8    = 3;
  localparam int SH_K2    = 1;

  localparam logic [EXP_W-1:0]   EXP_MAX         = EXP_W'(18);
  localparam logic [ALU_W-1:0]   RATE_MAX        = ALU_W'({RATE_W{1'b1}});
  localparam logic [LIMIT_W-1:0] RANGE_LIMIT_RST = LIMIT_W'(100);

  typedef logic [EXP_W-1:0] exp_t;

  typedef struct packed {
    logic             sub;
    logic [ALU_W-1:0] a;
    logic [ALU_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic [ALU_W-1:0] res;
    logic             carry;   // borrow when subtracting
  } alu_rsp_t;

  typedef struct packed {
    logic               push;
    exp_t               push_exp;
    logic [HIST_IW-1:0] rd_idx;
  } hist_ctl_t;
endpackage
`default_nettype wire

// ===== hw/rtl/arm_if.sv =====
// Word channels of the rate meter: sample in, result out.
`default_nettype none
interface arm_in_if import arm_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [CNT_IN_W-1:0]  counter_value;
  logic [ELAPSED_W-1:0] elapsed_ms;
  modport source (output valid, counter_value, elapsed_ms, input ready);
  modport sink (input valid, counter_value, elapsed_ms, output ready);
endinterface

interface arm_out_if import arm_pkg::*;;
  logic              valid;
  logic              ready;
  logic [RATE_W-1:0] rate_per_sec;
  logic [EXP_W-1:0]  own_exponent;
  logic [EXP_W-1:0]  display_exponent;
  logic              counter_went_back;
  logic              sample_ignored;
  modport source (output valid, rate_per_sec, own_exponent, display_exponent,
                  counter_went_back, sample_ignored, input ready);
  modport sink (input valid, rate_per_sec, own_exponent, display_exponent,
                counter_went_back, sample_ignored, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/arm_alu.sv =====
// Shared 64-bit add/subtract unit; carry out doubles as compare result.
`default_nettype none
module arm_alu import arm_pkg::*; (
  input  alu_req_t req_i,
  output alu_rsp_t rsp_o
);
  logic [ALU_W:0] sum;

  always_comb begin
    if (req_i.sub) begin
      sum = {1'b0, req_i.a} - {1'b0, req_i.b};
    end else begin
      sum = {1'b0, req_i.a} + {1'b0, req_i.b};
    end
  end

  assign rsp_o.res   = sum[ALU_W-1:0];
  assign rsp_o.carry = sum[ALU_W];
endmodule
`default_nettype wire

// ===== hw/rtl/arm_hist.sv =====
// Exponent history: shift line of past exponents, oldest at index 0.
`default_nettype none
module arm_hist import arm_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  hist_ctl_t ctl_i,
  output exp_t      rd_data_o
);
  exp_t hist_q [HIST_SLOTS];
  exp_t hist_d [HIST_SLOTS];

  always_comb begin
    for (int i = 0; i < HIST_SLOTS; i++) begin
      hist_d[i] = hist_q[i];
    end
    if (ctl_i.push && (HIST_LEN > 0)) begin
      for (int i = 0; i < HIST_SLOTS - 1; i++) begin
        hist_d[i] = hist_q[i+1];
      end
      hist_d[HIST_SLOTS-1] = ctl_i.push_exp;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < HIST_SLOTS; i++) begin
        hist_q[i] <= '0;
      end
    end else begin
      for (int i = 0; i < HIST_SLOTS; i++) begin
        hist_q[i] <= hist_d[i];
      end
    end
  end

  assign rd_data_o = hist_q[ctl_i.rd_idx];
endmodule
`default_nettype wire

// ===== hw/rtl/autoranging_rate_meter.sv =====
// Top level: autoranging rate meter with peak-hold decade exponent.
//
//  channel  dir  handshake     word
//  in_i     in   valid/ready   counter_value[47:0], elapsed_ms[31:0]
//  out_o    out  valid/ready   rate_per_sec[57:0], own_exponent[4:0],
//                              display_exponent[4:0], counter_went_back,
//                              sample_ignored
//  cfg      in   cfg_we_i      cfg_wdata_i[15:0] -> range_limit
//
// Steps per word, from accept to result ready:
//   normal sample:  check, multiply, 58-step divider, clamp, decade search, 19-entry scan
//   held sample:    check, decade search, 19-entry scan (zero elapsed or counter back)
// The multiply, divide, decade search and history scan run through one 64-bit adder,
// so the divider's one quotient bit per cycle and the decade search set the rate.
// Reset clears count, rate, history and loads range_limit with 100.
// in_i.ready is high only while idle; a finished result waits in the output
// register, so the next word is taken while the previous one is unread.
`default_nettype none
`include "assert_macros.svh"
module autoranging_rate_meter import arm_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [LIMIT_W-1:0] cfg_wdata_i,
  arm_in_if.sink             in_i,
  arm_out_if.source          out_o
);
  // sequencer states
  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_CHK  = 4'd1;  // zero elapsed / counter back check
  localparam logic [3:0] ST_MUL1 = 4'd2;  // d*1024 - d*16
  localparam logic [3:0] ST_MUL2 = 4'd3;  //        - d*8
  localparam logic [3:0] ST_DIV  = 4'd4;  // restoring divide, one bit a cycle
  localparam logic [3:0] ST_SAT  = 4'd5;  // clamp and commit rate
  localparam logic [3:0] ST_DEC  = 4'd6;  // rate <= bound ?
  localparam logic [3:0] ST_X10  = 4'd7;  // bound *= 10
  localparam logic [3:0] ST_SCAN = 4'd8;  // history max
  localparam logic [3:0] ST_FIN  = 4'd9;  // hand result to output register

  logic [3:0]             state_q, state_d;
  logic [LIMIT_W-1:0]     range_limit_q, range_limit_d;
  logic [COUNT_WIDTH-1:0] last_count_q, last_count_d;
  logic [RATE_W-1:0]      last_rate_q, last_rate_d;

  // working registers, no reset needed
  logic [COUNT_WIDTH-1:0] count_q, count_d;
  logic [ELAPSED_W-1:0]   elapsed_q, elapsed_d;
  logic [COUNT_WIDTH-1:0] diff_q, diff_d;
  logic [NUM_W-1:0]       num_q, num_d;      // numerator, then quotient
  logic [ELAPSED_W-1:0]   rem_q, rem_d;
  logic [DIV_CW-1:0]      div_cnt_q, div_cnt_d;
  logic [ALU_W-1:0]       bound_q, bound_d;  // range_limit * 10^k, mod 2^64
  exp_t                   exp_q, exp_d;
  exp_t                   max_q, max_d;
  logic [HIST_CW-1:0]     scan_q, scan_d;
  logic                   normal_q, normal_d;
  logic                   went_back_q, went_back_d;
  logic                   ignored_q, ignored_d;

  // output register
  logic                   out_valid_q, out_valid_d;
  logic [RATE_W-1:0]      out_rate_q, out_rate_d;
  exp_t                   out_own_q, out_own_d;
  exp_t                   out_disp_q, out_disp_d;
  logic                   out_wb_q, out_wb_d;
  logic                   out_ign_q, out_ign_d;

  alu_req_t  alu_req;
  alu_rsp_t  alu_rsp;
  hist_ctl_t hist_ctl;
  exp_t      hist_rd;
  logic      in_acc;
  logic [ELAPSED_W:0] div_trial;   // partial remainder shifted by one bit

  arm_alu u_alu (
    .req_i (alu_req),
    .rsp_o (alu_rsp)
  );

  arm_hist u_hist (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (hist_ctl),
    .rd_data_o (hist_rd)
  );

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign div_trial  = {rem_q, num_q[NUM_W-1]};

  // operand select for the shared adder
  always_comb begin
    alu_req.sub = 1'b1;
    alu_req.a   = '0;
    alu_req.b   = '0;
    case (state_q)
      ST_CHK: begin
        alu_req.a = ALU_W'(count_q);
        alu_req.b = ALU_W'(last_count_q);
      end
      ST_MUL1: begin
        alu_req.a = ALU_W'(diff_q) << SH_K1024;
        alu_req.b = ALU_W'(diff_q) << SH_K16;
      end
      ST_MUL2: begin
        alu_req.a = ALU_W'(num_q);
        alu_req.b = ALU_W'(diff_q) << SH_K8;
      end
      ST_DIV: begin
        alu_req.a = ALU_W'(div_trial);
        alu_req.b = ALU_W'(elapsed_q);
      end
      ST_DEC: begin
        alu_req.a = bound_q;
        alu_req.b = ALU_W'(last_rate_q);
      end
      ST_X10: begin
        alu_req.sub = 1'b0;
        alu_req.a   = bound_q << SH_K8;
        alu_req.b   = bound_q << SH_K2;
      end
      ST_SCAN: begin
        alu_req.a = ALU_W'(max_q);
        alu_req.b = ALU_W'(hist_rd);
      end
      default: begin
        alu_req.sub = 1'b0;
      end
    endcase
  end

  // sequencer
  always_comb begin
    state_d       = state_q;
    range_limit_d = range_limit_q;
    last_count_d  = last_count_q;
    last_rate_d   = last_rate_q;
    count_d       = count_q;
    elapsed_d     = elapsed_q;
    diff_d        = diff_q;
    num_d         = num_q;
    rem_d         = rem_q;
    div_cnt_d     = div_cnt_q;
    bound_d       = bound_q;
    exp_d         = exp_q;
    max_d         = max_q;
    scan_d        = scan_q;
    normal_d      = normal_q;
    went_back_d   = went_back_q;
    ignored_d     = ignored_q;
    out_valid_d   = out_valid_q;
    out_rate_d    = out_rate_q;
    out_own_d     = out_own_q;
    out_disp_d    = out_disp_q;
    out_wb_d      = out_wb_q;
    out_ign_d     = out_ign_q;
    hist_ctl.push     = 1'b0;
    hist_ctl.push_exp = exp_q;
    hist_ctl.rd_idx   = scan_q[HIST_IW-1:0];

    if (cfg_we_i) begin
      range_limit_d = cfg_wdata_i;
    end
    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          count_d   = COUNT_WIDTH'(in_i.counter_value);
          elapsed_d = in_i.elapsed_ms;
          state_d   = ST_CHK;
        end
      end
      ST_CHK: begin
        went_back_d = 1'b0;
        ignored_d   = 1'b0;
        normal_d    = 1'b0;
        bound_d     = ALU_W'(range_limit_q);
        exp_d       = '0;
        if (elapsed_q == '0) begin
          ignored_d = 1'b1;
          state_d   = ST_DEC;
        end else if (alu_rsp.carry) begin
          // counter went back: only the stored count moves
          went_back_d  = 1'b1;
          last_count_d = count_q;
          state_d      = ST_DEC;
        end else begin
          normal_d = 1'b1;
          diff_d   = alu_rsp.res[COUNT_WIDTH-1:0];
          state_d  = ST_MUL1;
        end
      end
      ST_MUL1: begin
        num_d   = alu_rsp.res[NUM_W-1:0];
        state_d = ST_MUL2;
      end
      ST_MUL2: begin
        num_d     = alu_rsp.res[NUM_W-1:0];
        rem_d     = '0;
        div_cnt_d = '0;
        state_d   = ST_DIV;
      end
      ST_DIV: begin
        if (alu_rsp.carry) begin
          rem_d = div_trial[ELAPSED_W-1:0];
        end else begin
          rem_d = alu_rsp.res[ELAPSED_W-1:0];
        end
        num_d     = {num_q[NUM_W-2:0], ~alu_rsp.carry};
        div_cnt_d = div_cnt_q + DIV_CW'(1);
        if (div_cnt_q == DIV_CW'(NUM_W - 1)) begin
          state_d = ST_SAT;
        end
      end
      ST_SAT: begin
        if (ALU_W'(num_q) > RATE_MAX) begin
          last_rate_d = RATE_MAX[RATE_W-1:0];
        end else begin
          last_rate_d = RATE_W'(num_q);
        end
        last_count_d = count_q;
        bound_d      = ALU_W'(range_limit_q);
        exp_d        = '0;
        state_d      = ST_DEC;
      end
      ST_DEC: begin
        if ((exp_q == EXP_MAX) || !alu_rsp.carry) begin
          // exponent settled; on a normal sample the new exponent enters the history
          hist_ctl.push = normal_q;
          max_d  = normal_q ? exp_q : '0;
          scan_d = '0;
          state_d = (HIST_LEN > 0) ? ST_SCAN : ST_FIN;
        end else begin
          state_d = ST_X10;
        end
      end
      ST_X10: begin
        bound_d = alu_rsp.res;
        exp_d   = exp_q + EXP_W'(1);
        state_d = ST_DEC;
      end
      ST_SCAN: begin
        if (alu_rsp.carry) begin
          max_d = hist_rd;
        end
        scan_d = scan_q + HIST_CW'(1);
        if (scan_q == HIST_CW'(HIST_LEN - 1)) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_rate_d  = last_rate_q;
          out_own_d   = exp_q;
          out_disp_d  = max_q;
          out_wb_d    = went_back_q;
          out_ign_d   = ignored_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      range_limit_q <= RANGE_LIMIT_RST;
      last_count_q  <= '0;
      last_rate_q   <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      range_limit_q <= range_limit_d;
      last_count_q  <= last_count_d;
      last_rate_q   <= last_rate_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    count_q     <= count_d;
    elapsed_q   <= elapsed_d;
    diff_q      <= diff_d;
    num_q       <= num_d;
    rem_q       <= rem_d;
    div_cnt_q   <= div_cnt_d;
    bound_q     <= bound_d;
    exp_q       <= exp_d;
    max_q       <= max_d;
    scan_q      <= scan_d;
    normal_q    <= normal_d;
    went_back_q <= went_back_d;
    ignored_q   <= ignored_d;
    out_rate_q  <= out_rate_d;
    out_own_q   <= out_own_d;
    out_disp_q  <= out_disp_d;
    out_wb_q    <= out_wb_d;
    out_ign_q   <= out_ign_d;
  end

  assign out_o.valid             = out_valid_q;
  assign out_o.rate_per_sec      = out_rate_q;
  assign out_o.own_exponent      = out_own_q;
  assign out_o.display_exponent  = out_disp_q;
  assign out_o.counter_went_back = out_wb_q;
  assign out_o.sample_ignored    = out_ign_q;

  // exponents never leave the decade range
  `ARM_ASSERT(a_exp_range, clk_i, rst_ni, out_o.valid |-> (out_o.own_exponent <= EXP_MAX) && (out_o.display_exponent <= EXP_MAX))
  // a word is either held for a zero interval or for a backward counter, not both
  `ARM_ASSERT_NEVER(a_flags_excl, clk_i, rst_ni, out_o.valid && out_o.counter_went_back && out_o.sample_ignored)
  // on a fresh sample the window maximum includes the new exponent
  `ARM_ASSERT(a_disp_ge_own, clk_i, rst_ni, (out_o.valid && !out_o.counter_went_back && !out_o.sample_ignored) |-> (out_o.display_exponent >= out_o.own_exponent))
  // the sequencer is busy the cycle after taking a word
  `ARM_ASSERT(a_busy_after_acc, clk_i, rst_ni, in_acc |=> !in_i.ready)
endmodule
`default_nettype wire

// ===== tb/sv/tb_autoranging_rate_meter.sv =====
// Self-checking testbench of the autoranging rate meter: directed table, then random phases.
module tb_autoranging_rate_meter import arm_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HALF_PERIOD = 2;
  localparam int RESET_CYCLES = 11;
  // Longer than the slowest word (full divide, 18 decades, scan); leave margin after the drain.
  localparam int DRAIN_CYCLES = 150;
  // Every word gives a result, so the block is idle once the last one is read.
  localparam int SETTLE_CYCLES = 4;
  localparam int PHASES = 8;
  localparam int WORDS_PER_PHASE = 136;
  localparam logic [63:0] MS_PER_SEC = 64'd1000;
  localparam logic [63:0] DECADE = 64'd10;
  localparam logic [CNT_IN_W-1:0] COUNT_FULL = '1;

  // Idle mix per phase: none, sender idle, receiver stalling, both.
  localparam int SEND_IDLE_PCT [4] = '{0, 68, 0, 33};
  localparam int RECV_STALL_PCT [4] = '{0, 0, 68, 33};
  // Range limit per random phase; phases 3 and 6 draw a random one instead.
  localparam logic [LIMIT_W-1:0] PHASE_LIMITS [PHASES] =
    '{16'd1, 16'd65535, 16'd0, 16'd0, 16'd10, 16'd100, 16'd0, 16'd3};

  typedef struct packed {
    logic [RATE_W-1:0] rate;
    exp_t              own;
    exp_t              disp;
    logic              went_back;
    logic              ignored;
  } meter_word_t;

  typedef struct packed {
    logic [CNT_IN_W-1:0]  cnt;
    logic [ELAPSED_W-1:0] el;
    logic                 typed;   // want holds a hand-worked result
    meter_word_t          want;
  } sample_row_t;

  // Directed words, all at the reset range limit of 100 and with no idling.
  localparam sample_row_t DIRECTED_ROWS [16] = '{
    // zero elapsed right after reset: nothing to hold but zeros
    '{48'h0, 32'h0, 1'b1, '{58'd0, 5'd0, 5'd0, 1'b0, 1'b1}},
    // smallest elapsed, no counts
    '{48'h0, 32'h1, 1'b1, '{58'd0, 5'd0, 5'd0, 1'b0, 1'b0}},
    // full-scale jump in one millisecond: the largest rate the counter allows
    '{48'hFFFF_FFFF_FFFF, 32'h1, 1'b1,
      '{58'd281474976710655000, 5'd16, 5'd16, 1'b0, 1'b0}},
    // counter went back: rate and peak held
    '{48'h5, 32'hFFFF_FFFF, 1'b1,
      '{58'd281474976710655000, 5'd16, 5'd16, 1'b1, 1'b0}},
    // no change over the longest elapsed time; peak still held by history
    '{48'h5, 32'hFFFF_FFFF, 1'b1, '{58'd0, 5'd0, 5'd16, 1'b0, 1'b0}},
    // zero elapsed wins over a lower count
    '{48'h0, 32'h0, 1'b1, '{58'd0, 5'd0, 5'd16, 1'b0, 1'b1}},
    // decade boundaries: rate 100, 101, 1000, 1001
    '{48'd105, 32'd1000, 1'b0, '0},
    '{48'd206, 32'd1000, 1'b0, '0},
    '{48'd1206, 32'd1000, 1'b0, '0},
    '{48'd2207, 32'd1000, 1'b0, '0},
    // alternating bit patterns
    '{48'hAAAA_AAAA_AAAA, 32'h5555_5555, 1'b0, '0},
    '{48'hFFFF_FFFF_FFFF, 32'hAAAA_AAAA, 1'b0, '0},
    '{48'h5555_5555_5555, 32'h1, 1'b0, '0},
    '{48'h5555_5555_5555, 32'h0, 1'b0, '0},
    '{48'h8000_0000_0000, 32'd7, 1'b0, '0},
    '{48'h8000_0000_0001, 32'h8000_0000, 1'b0, '0}
  };

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [LIMIT_W-1:0] cfg_wdata_i = '0;

  arm_in_if  in_if ();
  arm_out_if out_if ();

  autoranging_rate_meter dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  always #(HALF_PERIOD) clk_i = ~clk_i;

  // Predictor state: mirror of the meter's registers and range limit.
  logic [LIMIT_W-1:0]     limit_model;
  logic [COUNT_WIDTH-1:0] count_model;
  logic [RATE_W-1:0]      rate_model;
  exp_t                   exp_hist [HIST_SLOTS];   // oldest first

  meter_word_t expected_words [$];
  meter_word_t oldest_word;
  int mismatch_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  // Printing stops after a couple hundred mismatches; counting does not.
  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (mismatch_count < 200)
      $display("%0t ns: %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // Smallest k <= 18 with rate <= limit * 10^k. The product wraps at 64 bits
  // just as the block's adder does.
  function automatic exp_t decade_of_rate(input logic [RATE_W-1:0] rate);
    logic [63:0] scale;
    exp_t k;
    scale = 64'd1;
    k = '0;
    while (k < EXP_MAX && 64'(rate) > 64'(limit_model) * scale) begin
      scale = scale * DECADE;
      k++;
    end
    return k;
  endfunction

  function automatic exp_t history_peak();
    exp_t peak;
    peak = '0;
    for (int i = 0; i < HIST_LEN; i++)
      if (exp_hist[i] > peak) peak = exp_hist[i];
    return peak;
  endfunction

  // Result of one sample; advances the predictor state.
  function automatic meter_word_t predict_meter_word(input logic [CNT_IN_W-1:0] cnt,
                                                     input logic [ELAPSED_W-1:0] el);
    meter_word_t w;
    logic [COUNT_WIDTH-1:0] c;
    logic [63:0] q;
    c = cnt[COUNT_WIDTH-1:0];
    w = '0;
    if (el == '0 || c < count_model) begin
      // held sample: last rate re-ranged under the current limit
      w.rate = rate_model;
      w.own = decade_of_rate(rate_model);
      w.disp = history_peak();
      w.ignored = (el == '0);
      w.went_back = !w.ignored;
      if (w.went_back) count_model = c;
      return w;
    end
    q = (64'(c - count_model) * MS_PER_SEC) / 64'(el);
    if (q > RATE_MAX) q = RATE_MAX;
    count_model = c;
    rate_model = q[RATE_W-1:0];
    w.rate = rate_model;
    w.own = decade_of_rate(rate_model);
    w.disp = w.own;
    // shift out the oldest exponent; peak covers the new window only
    for (int i = 0; i + 1 < HIST_LEN; i++) begin
      exp_hist[i] = exp_hist[i + 1];
      if (exp_hist[i] > w.disp) w.disp = exp_hist[i];
    end
    if (HIST_LEN > 0) exp_hist[HIST_LEN - 1] = w.own;
    return w;
  endfunction

  // Drives one word at the falling edge and holds it until taken. The
  // prediction is made at the accepting edge, so the next random word is
  // drawn from up-to-date state.
  task automatic send_sample(input logic [CNT_IN_W-1:0] cnt, input logic [ELAPSED_W-1:0] el,
                             input logic typed, input meter_word_t want);
    meter_word_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.counter_value <= cnt;
    in_if.elapsed_ms <= el;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    predicted = predict_meter_word(cnt, el);
    expected_words.push_back(typed ? want : predicted);
    @(negedge clk_i);
  endtask

  // Stop sending and wait until every pending result has been read.
  task automatic settle_idle();
    in_if.valid <= 1'b0;
    while (expected_words.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_range_limit(input logic [LIMIT_W-1:0] value);
    settle_idle();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    limit_model = value;
  endtask

  // Mostly well-formed: a rising counter with deltas and elapsed times of
  // random magnitude, so rates cross many decades. The rest is zero elapsed,
  // counter going back and fully random words.
  task automatic pick_random_sample(output logic [CNT_IN_W-1:0] cnt,
                                    output logic [ELAPSED_W-1:0] el);
    int unsigned kind;
    int unsigned delta_bits;
    logic [63:0] wide;
    logic [CNT_IN_W:0] mask;
    logic [CNT_IN_W:0] sum;
    kind = $urandom_range(99);
    wide = {$urandom, $urandom};
    cnt = wide[CNT_IN_W-1:0];
    el = $urandom;
    if (kind < 6) begin
      el = '0;
    end else if (kind < 13 && count_model != '0) begin
      cnt = cnt % count_model;
    end else if (kind >= 17) begin
      delta_bits = ($urandom_range(15) == 0) ? $urandom_range(41, CNT_IN_W)
                                             : $urandom_range(0, 40);
      mask = ((CNT_IN_W + 1)'(1) << delta_bits) - 1'b1;
      sum = {1'b0, count_model} + ({1'b0, cnt} & mask);
      cnt = sum[CNT_IN_W] ? COUNT_FULL : sum[CNT_IN_W-1:0];
      el = el & ELAPSED_W'((64'd1 << $urandom_range(1, ELAPSED_W)) - 1);
      if (el == '0) el = 1;
    end
  endtask

  // Receiver: ready changes at the falling edge only.
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Scoreboard: each word read is matched against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (expected_words.size() == 0) begin
        report_mismatch("result word with nothing pending", 64'(out_if.rate_per_sec), 64'd0);
      end else begin
        oldest_word = expected_words.pop_front();
        if (out_if.rate_per_sec !== oldest_word.rate)
          report_mismatch("rate_per_sec", 64'(out_if.rate_per_sec), 64'(oldest_word.rate));
        if (out_if.own_exponent !== oldest_word.own)
          report_mismatch("own_exponent", 64'(out_if.own_exponent), 64'(oldest_word.own));
        if (out_if.display_exponent !== oldest_word.disp)
          report_mismatch("display_exponent", 64'(out_if.display_exponent),
                          64'(oldest_word.disp));
        if (out_if.counter_went_back !== oldest_word.went_back)
          report_mismatch("counter_went_back", 64'(out_if.counter_went_back),
                          64'(oldest_word.went_back));
        if (out_if.sample_ignored !== oldest_word.ignored)
          report_mismatch("sample_ignored", 64'(out_if.sample_ignored),
                          64'(oldest_word.ignored));
      end
    end
  end

  // Stimulus and end of run.
  initial begin
    logic [CNT_IN_W-1:0] cnt;
    logic [ELAPSED_W-1:0] el;
    logic [LIMIT_W-1:0] lim;
    in_if.valid = 1'b0;
    in_if.counter_value = '0;
    in_if.elapsed_ms = '0;
    limit_model = RANGE_LIMIT_RST;
    count_model = '0;
    rate_model = '0;
    foreach (exp_hist[i]) exp_hist[i] = '0;

    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (DIRECTED_ROWS[i])
      send_sample(DIRECTED_ROWS[i].cnt, DIRECTED_ROWS[i].el, DIRECTED_ROWS[i].typed,
                  DIRECTED_ROWS[i].want);

    // Each phase: new range limit while idle, then random words under one idle mix.
    for (int p = 0; p < PHASES; p++) begin
      lim = (p == 3 || p == 6) ? LIMIT_W'($urandom_range(1, 65535)) : PHASE_LIMITS[p];
      write_range_limit(lim);
      send_idle_pct = SEND_IDLE_PCT[p % 4];
      recv_stall_pct = RECV_STALL_PCT[p % 4];
      repeat (WORDS_PER_PHASE) begin
        pick_random_sample(cnt, el);
        send_sample(cnt, el, 1'b0, '0);
      end
    end

    settle_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && expected_words.size() == 0)
      $display("autoranging_rate_meter regression: pass");
    else
      $display("autoranging_rate_meter regression: fail");
    $finish;
  end

  // Watchdog: several times the slowest expected run.
  initial begin
    #4_000_000;
    $display("autoranging_rate_meter regression: fail");
    $finish;
  end
endmodule
